>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising edge outside reset
`define NFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked on every rising edge outside reset
`define NFQ_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define NFQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define NFQ_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/nfq_pkg.sv
// shared types and constants for the negative-value fifo with min/max
package nfq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    // control of the shared compare unit
    typedef struct packed {
        logic clear;
        logic load;
    } t_mm_ctl;

endpackage

>>> rtl/nfq_mem.sv
// slot storage: one write port, one registered read port
module nfq_mem import nfq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/nfq_minmax.sv
// shared compare unit: tracks front, largest and smallest over a scan
module nfq_minmax import nfq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mm_ctl                 i_ctl,
    input  logic signed [VAL_W-1:0] i_data,
    output logic                    o_have,
    output logic signed [VAL_W-1:0] o_front,
    output logic signed [VAL_W-1:0] o_largest,
    output logic signed [VAL_W-1:0] o_smallest
);

    logic                    r_have;
    logic signed [VAL_W-1:0] r_front, r_max, r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (i_ctl.load) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (!r_have) begin
                // first word seen is the front
                r_front <= i_data;
                r_max   <= i_data;
                r_min   <= i_data;
            end else begin
                if (i_data > r_max) r_max <= i_data;
                if (i_data < r_min) r_min <= i_data;
            end
        end
    end

    assign o_have     = r_have;
    assign o_front    = r_front;
    assign o_largest  = r_max;
    assign o_smallest = r_min;

endmodule

>>> rtl/negative_fifo_with_min_max.sv
// an action is accepted in idle, the live words are then scanned from the head, then the result is registered
// a pop scans the old count: the first word read is the popped word, else count after the action
// a new action is accepted only after the result of the last one is loaded into the output register
// input ready only in idle; a result still held in the output register stalls the block
// synchronous active-low reset empties the queue; slot contents need no reset
`include "assert_macros.svh"
module negative_fifo_with_min_max import nfq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_W = ((4 * VAL_W + 1 + CW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // push_value
    input  logic [1:0]       i_s_tuser,   // action
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // popped_value, front_value, is_empty,
                                          // entry_count, largest_value, smallest_value, pad
    output logic [1:0]       o_m_tuser    // status
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_head, n_head, r_tail, n_tail, r_ptr, n_ptr;
    logic [CW-1:0]           r_count, n_count, r_left, n_left;
    logic                    r_skip, n_skip, r_rd_v, n_rd_v;
    logic signed [VAL_W-1:0] r_popped, n_popped;
    logic [1:0]              r_status, n_status;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic [1:0]              r_out_user;

    logic                    acc, out_load, wr_en, rd_en;
    logic signed [VAL_W-1:0] push_val, rd_data;
    logic signed [VAL_W-1:0] mm_front, mm_max, mm_min;
    logic                    mm_have;
    t_mm_ctl                 mm_ctl;

    assign push_val   = signed'(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign acc        = i_s_tvalid & o_s_tready;
    assign wr_en      = acc && (i_s_tuser == ACT_PUSH) && push_val[VAL_W-1]
                        && (r_count != FULL_CNT);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_skip   = r_skip;
        n_rd_v   = 1'b0;
        n_popped = r_popped;
        n_status = r_status;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_status = ST_DONE;
                    n_skip   = 1'b0;
                    n_popped = '0;
                    case (i_s_tuser)
                        ACT_PUSH: begin
                            if (!push_val[VAL_W-1]) begin
                                n_status = ST_IGNORE;
                            end else if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                n_skip  = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    // scan starts at the old head; a pop reads its word first
                    n_ptr   = (i_s_tuser == ACT_CLEAR) ? '0 : r_head;
                    n_left  = n_skip ? r_count : n_count;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_rd_v = 1'b1;
                    n_ptr  = (r_ptr == LAST_PTR) ? '0 : r_ptr + 1'b1;
                    n_left = r_left - 1'b1;
                end
                if (r_rd_v && r_skip) begin
                    n_popped = rd_data;
                    n_skip   = 1'b0;
                end
                if (r_left == '0 && !r_rd_v) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign mm_ctl.clear = acc;
    assign mm_ctl.load  = r_rd_v && !r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_rd_v  <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_left  <= n_left;
            r_rd_v  <= n_rd_v;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_popped <= n_popped;
        r_status <= n_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= OUT_W'({
                (mm_have ? mm_min   : {VAL_W{1'b0}}),
                (mm_have ? mm_max   : {VAL_W{1'b0}}),
                r_count,
                (r_count == '0),
                (mm_have ? mm_front : {VAL_W{1'b0}}),
                r_popped});
            r_out_user <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    nfq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_tail),
        .i_wdata (push_val),
        .i_re    (rd_en),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    nfq_minmax u_minmax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mm_ctl),
        .i_data     (rd_data),
        .o_have     (mm_have),
        .o_front    (mm_front),
        .o_largest  (mm_max),
        .o_smallest (mm_min)
    );

    `NFQ_ASSERT(a_count_max, i_clk, i_rst_n, (r_count <= FULL_CNT), "fill count beyond depth")
    `NFQ_ASSERT(a_ptr_match, i_clk, i_rst_n,
        ((r_count == '0 || r_count == FULL_CNT) == (r_head == r_tail)),
        "pointers disagree with fill count")
    `NFQ_ASSERT_IMP(a_rd_in_scan, i_clk, i_rst_n, r_rd_v, (r_state == S_SCAN),
        "read data outside scan")
    `NFQ_ASSERT_IMP(a_left_bound, i_clk, i_rst_n, (r_state == S_SCAN),
        (r_left <= FULL_CNT), "scan length beyond depth")

endmodule
